FILE: rtl/ags_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ags_pkg
// Shared widths, constants and controller/datapath bundles for the AdaGrad
// gradient scaler.
// ----------------------------------------------------------------------------
package ags_pkg;

    localparam int VECTOR_LENGTH = 1024;
    localparam int POS_W         = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

    localparam int GRAD_W   = 16;
    localparam int EPS_W    = 12;
    localparam int RES_W    = 16;
    localparam int MAG_W    = GRAD_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ACC_W    = 40;
    localparam int ROOT_W   = ACC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int DEN_W    = ROOT_W + 1;
    localparam int FRAC_SH  = 14;
    localparam int QUO_W    = FRAC_SH + 1;
    localparam int NUM_W    = MAG_W + FRAC_SH;
    localparam int DIV_W    = DEN_W + FRAC_SH;
    localparam int CNT_W    = 5;

    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
    localparam logic [QUO_W-1:0] RESULT_LIMIT = QUO_W'(16384);
    localparam logic [EPS_W-1:0] EPS_RESET    = EPS_W'(1);

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic square;
        logic accum;
        logic root_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pos_last;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/ags_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ags_ifs
// Valid/ready channels: gradient input, scaled result output, epsilon write.
// ----------------------------------------------------------------------------
interface ags_in_if import ags_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] gradient;
    logic                     last_element;

    modport source (output valid, gradient, last_element, input ready);
    modport sink   (input valid, gradient, last_element, output ready);
endinterface

interface ags_out_if import ags_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] scaled_gradient;
    logic                    end_of_vector;

    modport source (output valid, scaled_gradient, end_of_vector, input ready);
    modport sink   (input valid, scaled_gradient, end_of_vector, output ready);
endinterface

interface ags_cfg_if import ags_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ags_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ags_ctrl
// Sequencer: clearing sweep, per-beat accumulate, bit-serial root and divide,
// output register handoff.
// ----------------------------------------------------------------------------
module ags_ctrl import ags_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_ROOT,
        S_DINIT,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.clr_wr    = (r_state == S_CLEAR);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.accum     = (r_state == S_ACCUM);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.div_init  = (r_state == S_DINIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.pos_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: r_state <= S_ACCUM;
                S_ACCUM: begin
                    r_state <= S_ROOT;
                    r_cnt   <= '0;
                end
                S_ROOT: begin
                    if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_DINIT;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DINIT: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ags_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ags_dpath
// Accumulator memory, position counter, squarer, bit-serial square root,
// restoring divider and output register.
// ----------------------------------------------------------------------------
module ags_dpath import ags_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic signed [GRAD_W-1:0] i_gradient,
    input  wire logic                     i_last_element,
    input  wire logic                     i_cfg_we,
    input  wire logic [EPS_W-1:0]         i_cfg_data,
    output logic signed [RES_W-1:0]       o_scaled_gradient,
    output logic                          o_end_of_vector
);

    logic [ACC_W-1:0]  r_mem [VECTOR_LENGTH];
    logic [ACC_W-1:0]  r_rd;
    logic [POS_W-1:0]  r_pos;
    logic [EPS_W-1:0]  r_eps;
    logic              r_neg;
    logic              r_last;
    logic [MAG_W-1:0]  r_mag;
    logic [SQ_W-1:0]   r_sq;
    logic [ACC_W-1:0]  r_sqin;
    logic [REM_W-3:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [NUM_W-1:0]  r_drem;
    logic [DIV_W-1:0]  r_div;
    logic [QUO_W-1:0]  r_q;
    logic              r_dzero;
    logic [RES_W-1:0]  r_res;
    logic              r_eov;

    logic              pos_last;
    logic [POS_W-1:0]  n_pos;
    logic [MAG_W-1:0]  mag;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic              mem_we;
    logic [ACC_W-1:0]  mem_wdata;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_diff;
    logic              root_ge;
    logic [DEN_W-1:0]  den;
    logic              div_ge;
    logic [QUO_W-1:0]  q_sat;
    logic [RES_W-1:0]  q_ext;

    assign pos_last = (r_pos == POS_W'(VECTOR_LENGTH - 1));
    assign o_sts.pos_last = pos_last;

    assign mag = i_gradient[GRAD_W-1] ? (MAG_W'(0) - {i_gradient[GRAD_W-1], i_gradient})
                                      : {1'b0, i_gradient};

    assign acc_sum   = {1'b0, r_rd} + (ACC_W + 1)'(r_sq);
    assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    assign mem_we    = i_cmd.clr_wr || i_cmd.accum;
    assign mem_wdata = i_cmd.clr_wr ? '0 : acc_sat;

    always_comb begin
        if (i_cmd.clr_wr) begin
            n_pos = pos_last ? '0 : r_pos + 1'b1;
        end else if (r_last || pos_last) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign rem_sh   = {r_rem, r_sqin[ACC_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign rem_diff = rem_sh - trial;
    assign root_ge  = (rem_sh >= trial);

    assign den    = DEN_W'(r_root) + DEN_W'(r_eps);
    assign div_ge = (DIV_W'(r_drem) >= r_div);

    assign q_sat = r_dzero ? '0 : ((r_q > RESULT_LIMIT) ? RESULT_LIMIT : r_q);
    assign q_ext = RES_W'(q_sat);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_eps <= EPS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_data;
            end
            if (mem_we) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= mag;
            r_neg  <= i_gradient[GRAD_W-1];
            r_last <= i_last_element;
        end
        if (i_cmd.square) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_cmd.accum) begin
            r_sqin <= acc_sat;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_sqin <= {r_sqin[ACC_W-3:0], 2'b00};
            if (root_ge) begin
                r_rem  <= rem_diff[REM_W-3:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-3:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_dzero <= (den == '0);
            r_div   <= {den, {FRAC_SH{1'b0}}};
            r_drem  <= {r_mag, {FRAC_SH{1'b0}}};
            r_q     <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_drem <= r_drem - r_div[NUM_W-1:0];
            end
            r_q   <= {r_q[QUO_W-2:0], div_ge};
            r_div <= r_div >> 1;
        end
        if (i_cmd.out_load) begin
            r_res <= r_neg ? (RES_W'(0) - q_ext) : q_ext;
            r_eov <= r_last;
        end
    end

    assign o_scaled_gradient = r_res;
    assign o_end_of_vector   = r_eov;

endmodule
`default_nettype wire

FILE: rtl/adagrad_gradient_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adagrad_gradient_scaler
// AdaGrad scaling of a gradient vector, one element per beat.
// ----------------------------------------------------------------------------
// Each accepted gradient adds its square to the accumulator of the current
// vector position (1024 positions, saturating Q16.24) and returns
// gradient / (floor(sqrt(accumulator)) + epsilon) in Q1.14. From acceptance to a
// loaded result an element passes through accept and memory read, square,
// accumulate and write back, the bit-serial root (one result bit per cycle),
// divider setup, the restoring divide and the output load. A new element is
// taken as soon as the previous one reaches the output register, while that
// result still waits to be taken. After reset the accumulator memory is
// cleared in a pass over all 1024 entries, one entry per cycle, during which
// no gradient is accepted; epsilon writes are taken at any time.
// ----------------------------------------------------------------------------
module adagrad_gradient_scaler import ags_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ags_in_if.sink   i_in,
    ags_out_if.source o_out,
    ags_cfg_if.sink  i_cfg
);

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    ags_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ags_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_gradient        (i_in.gradient),
        .i_last_element    (i_in.last_element),
        .i_cfg_we          (i_cfg.valid && i_cfg.ready),
        .i_cfg_data        (i_cfg.data),
        .o_scaled_gradient (o_out.scaled_gradient),
        .o_end_of_vector   (o_out.end_of_vector)
    );

endmodule
`default_nettype wire

FILE: rtl/ags_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ags_checker
// Port-level checks: result handshake, beat accounting, clearing after reset.
// ----------------------------------------------------------------------------
module ags_checker import ags_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [RES_W-1:0] i_out_scaled_gradient,
    input wire logic             i_out_end_of_vector
);

    logic [1:0] r_outst;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before its beat");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_scaled_gradient) && $stable(i_out_end_of_vector))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (r_outst != 2'd0))
        else $error("result beat without an accepted gradient");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst != 2'd3)
        else $error("more than two gradients in flight");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("gradient accepted during clearing pass");

endmodule

bind adagrad_gradient_scaler ags_checker u_ags_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_scaled_gradient (o_out.scaled_gradient),
    .i_out_end_of_vector   (o_out.end_of_vector)
);
`default_nettype wire
